FILE: hw/rtl/cpfd_pkg.sv
// Shared types and codes for the common packet format item deframer.
package cpfd_pkg;

    // Parser position within the frame
    typedef enum logic [2:0] {
        PH_CNT_LO = 3'd0,
        PH_CNT_HI = 3'd1,
        PH_TYP_LO = 3'd2,
        PH_TYP_HI = 3'd3,
        PH_LEN_LO = 3'd4,
        PH_LEN_HI = 3'd5,
        PH_DATA   = 3'd6,
        PH_IGNORE = 3'd7
    } phase_t;

    // Per-byte event codes
    localparam logic [2:0] EV_HEADER  = 3'd0;
    localparam logic [2:0] EV_PAYLOAD = 3'd1;
    localparam logic [2:0] EV_LASTPAY = 3'd2;
    localparam logic [2:0] EV_EMPTY   = 3'd3;
    localparam logic [2:0] EV_IGNORED = 3'd4;

    // Frame status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_EARLY  = 2'd1;
    localparam logic [1:0] ST_INSIDE = 2'd2;
    localparam logic [1:0] ST_SHORT  = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_last;
    } item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [15:0] item_index;
        logic [15:0] item_type;
        logic [15:0] item_length;
        logic [7:0]  data_byte;
        logic [15:0] data_offset;
        logic        frame_done;
        logic [1:0]  frame_status;
    } result_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] declared_items;
        logic [15:0] items_finished;
        logic [7:0]  low_byte_hold;
        logic [15:0] current_type;
        logic [15:0] current_length;
        logic [15:0] payload_left;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:          PH_CNT_LO,
        declared_items: 16'd0,
        items_finished: 16'd0,
        low_byte_hold:  8'd0,
        current_type:   16'd0,
        current_length: 16'd0,
        payload_left:   16'd0
    };

endpackage

FILE: hw/rtl/cpfd_step.sv
// One parse step: byte plus parser state in, result and next state out.
module cpfd_step (
    input  cpfd_pkg::parse_state_t state_cur,
    input  cpfd_pkg::item_t        item,
    output cpfd_pkg::parse_state_t state_next,
    output cpfd_pkg::result_t      result_next
);

    logic [15:0] fin_inc;
    logic        all_done_inc;
    logic [15:0] left_dec;
    logic [15:0] len_full;
    logic [15:0] count_full;
    logic [1:0]  status;
    cpfd_pkg::parse_state_t st;

    assign fin_inc      = state_cur.items_finished + 16'd1;
    assign all_done_inc = (fin_inc >= state_cur.declared_items);
    assign left_dec     = state_cur.payload_left - 16'd1;
    assign len_full     = {item.in_byte, state_cur.current_length[7:0]};
    assign count_full   = {item.in_byte, state_cur.low_byte_hold};

    always_comb begin
        st          = state_cur;
        result_next = '0;
        status      = cpfd_pkg::ST_DONE;
        result_next.event_res = cpfd_pkg::EV_HEADER;
        case (state_cur.phase)
            cpfd_pkg::PH_CNT_LO: begin
                st.low_byte_hold = item.in_byte;
                st.phase         = cpfd_pkg::PH_CNT_HI;
                status           = cpfd_pkg::ST_SHORT;
            end
            cpfd_pkg::PH_CNT_HI: begin
                st.declared_items = count_full;
                st.items_finished = 16'd0;
                if (count_full == 16'd0) begin
                    st.phase = cpfd_pkg::PH_IGNORE;
                    status   = cpfd_pkg::ST_DONE;
                end else begin
                    st.phase = cpfd_pkg::PH_TYP_LO;
                    status   = cpfd_pkg::ST_EARLY;
                end
            end
            cpfd_pkg::PH_TYP_LO: begin
                st.current_type   = {8'd0, item.in_byte};
                st.current_length = 16'd0;
                st.phase          = cpfd_pkg::PH_TYP_HI;
                result_next.item_index = state_cur.items_finished;
                result_next.item_type  = {8'd0, item.in_byte};
                status = cpfd_pkg::ST_INSIDE;
            end
            cpfd_pkg::PH_TYP_HI: begin
                st.current_type = {item.in_byte, state_cur.current_type[7:0]};
                st.phase        = cpfd_pkg::PH_LEN_LO;
                result_next.item_index = state_cur.items_finished;
                result_next.item_type  = {item.in_byte, state_cur.current_type[7:0]};
                status = cpfd_pkg::ST_INSIDE;
            end
            cpfd_pkg::PH_LEN_LO: begin
                st.current_length = {8'd0, item.in_byte};
                st.phase          = cpfd_pkg::PH_LEN_HI;
                result_next.item_index  = state_cur.items_finished;
                result_next.item_type   = state_cur.current_type;
                result_next.item_length = {8'd0, item.in_byte};
                status = cpfd_pkg::ST_INSIDE;
            end
            cpfd_pkg::PH_LEN_HI: begin
                st.current_length = len_full;
                st.payload_left   = len_full;
                result_next.item_index  = state_cur.items_finished;
                result_next.item_type   = state_cur.current_type;
                result_next.item_length = len_full;
                if (len_full == 16'd0) begin
                    // empty item closes on its length byte
                    result_next.event_res = cpfd_pkg::EV_EMPTY;
                    st.items_finished = fin_inc;
                    st.phase  = all_done_inc ? cpfd_pkg::PH_IGNORE : cpfd_pkg::PH_TYP_LO;
                    status    = all_done_inc ? cpfd_pkg::ST_DONE : cpfd_pkg::ST_EARLY;
                end else begin
                    st.phase = cpfd_pkg::PH_DATA;
                    status   = cpfd_pkg::ST_INSIDE;
                end
            end
            cpfd_pkg::PH_DATA: begin
                result_next.item_index  = state_cur.items_finished;
                result_next.item_type   = state_cur.current_type;
                result_next.item_length = state_cur.current_length;
                result_next.data_byte   = item.in_byte;
                result_next.data_offset = state_cur.current_length - state_cur.payload_left;
                st.payload_left = left_dec;
                if (left_dec == 16'd0) begin
                    result_next.event_res = cpfd_pkg::EV_LASTPAY;
                    st.items_finished = fin_inc;
                    st.phase  = all_done_inc ? cpfd_pkg::PH_IGNORE : cpfd_pkg::PH_TYP_LO;
                    status    = all_done_inc ? cpfd_pkg::ST_DONE : cpfd_pkg::ST_EARLY;
                end else begin
                    result_next.event_res = cpfd_pkg::EV_PAYLOAD;
                    status = cpfd_pkg::ST_INSIDE;
                end
            end
            default: begin
                result_next.event_res  = cpfd_pkg::EV_IGNORED;
                result_next.item_index = state_cur.items_finished;
                status = cpfd_pkg::ST_DONE;
            end
        endcase

        result_next.frame_done   = item.frame_last;
        result_next.frame_status = item.frame_last ? status : cpfd_pkg::ST_DONE;
        // parser rearms for the next frame after its final byte
        state_next = item.frame_last ? cpfd_pkg::STATE_RESET : st;
    end

endmodule

FILE: hw/rtl/cpf_item_deframer.sv
// Top level of the common packet format item deframer.
//
// Streaming parser for a common packet format frame, one byte per request.
// The frame opens with a little-endian 16-bit item count; each counted item
// follows as a 16-bit type, a 16-bit length and that many payload bytes, all
// little-endian. Every input byte yields exactly one result: a header byte, a
// payload byte tagged with item index, type, length and offset, the last
// payload byte of an item, an empty-item mark on the length high byte of a
// zero-length item, or an ignored byte (past the counted items). The result
// for the byte marked frame_last carries frame_done and the frame status
// (complete, ended early at an item boundary, ended inside an item so the
// partial item must be dropped, or fewer than two bytes); the parser then
// returns to its reset state for the next frame.
// Throughput is one byte per clock, sustained, while m_ready stays high. A
// request accepted into the input register goes through one parse step in
// logic and lands in the result register, with m_valid high, once that
// register is free. s_ready stays high whenever the result register is free
// or is being drained in the same cycle, so a stall on the m_ side backs up
// through at most the two registers. Reset is synchronous on aresetn; there
// is no setup pass after it.
module cpf_item_deframer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cpfd_pkg::item_t     s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output cpfd_pkg::result_t   m_result
);

    // input stage
    logic                   in_valid_reg;
    cpfd_pkg::item_t        in_reg;

    // parser state and result stage
    cpfd_pkg::parse_state_t state_reg;
    cpfd_pkg::parse_state_t state_next;
    logic                   out_valid_reg;
    cpfd_pkg::result_t      result_reg;
    cpfd_pkg::result_t      result_next;

    logic advance;

    // move the held byte into the result register when that slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    cpfd_step u_step (
        .state_cur   (state_reg),
        .item        (in_reg),
        .state_next  (state_next),
        .result_next (result_next)
    );

    // control and parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= cpfd_pkg::STATE_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = result_reg;

    // the parser rearms once the final byte of a frame has been processed
    a_rearm_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_reg.frame_last) |=> (state_reg.phase == cpfd_pkg::PH_CNT_LO))
        else $error("parser not rearmed after frame end");

    // payload phase always has bytes left to consume
    a_data_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == cpfd_pkg::PH_DATA) |-> (state_reg.payload_left != 16'd0))
        else $error("payload phase with nothing left");

    // never more items finished than the count declared
    a_finished_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.items_finished <= state_reg.declared_items)
        else $error("items finished exceeds declared count");

    // payload offsets stay inside the declared length
    a_offset_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result.event_res == cpfd_pkg::EV_PAYLOAD ||
                     m_result.event_res == cpfd_pkg::EV_LASTPAY))
        |-> (m_result.data_offset < m_result.item_length))
        else $error("payload offset beyond item length");

    // status is only reported on the final byte
    a_status_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_result.frame_done) |-> (m_result.frame_status == cpfd_pkg::ST_DONE))
        else $error("frame status set before frame end");

endmodule
